// ===== rtl/channel_lifecycle_controller_assert.svh =====
// assertion macros used by channel_lifecycle_controller
`ifndef CHANNEL_LIFECYCLE_CONTROLLER_ASSERT_SVH
`define CHANNEL_LIFECYCLE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define CLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clc assertion failed");

// next-cycle implication
`define CLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("clc assertion failed");

`endif

// ===== rtl/clc_pkg.sv =====
`default_nettype none
package clc_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int STAT_BITS   = 32;

	// effective length width: the length field itself is 16 bits
	localparam int LEN_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

	localparam int RUN_MAX   = 3;
	localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);
	localparam int RUN_IDX_W = $clog2(RUN_MAX);

	typedef enum logic [0:0] {
		CFG_STATS_ENABLE  = 1'd0,
		CFG_NOTIFY_ENABLE = 1'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_OPEN       = 3'd0,
		OP_CLOSE      = 3'd1,
		OP_READ       = 3'd2,
		OP_WRITE      = 3'd3,
		OP_OPEN_DONE  = 3'd4,
		OP_READ_DONE  = 3'd5,
		OP_WRITE_DONE = 3'd6
	} op_t;

	typedef enum logic [3:0] {
		ACT_NONE          = 4'd0,
		ACT_INVALID       = 4'd1,
		ACT_OPEN          = 4'd2,
		ACT_CLOSE         = 4'd3,
		ACT_ABORT_OPEN    = 4'd4,
		ACT_READ          = 4'd5,
		ACT_WRITE         = 4'd6,
		ACT_OPEN_ENDED    = 4'd7,
		ACT_OPEN_FAIL_HK  = 4'd8,
		ACT_OPEN_OK_HK    = 4'd9,
		ACT_UP_OPEN_FAIL  = 4'd10,
		ACT_UP_LAYER_UP   = 4'd11,
		ACT_UP_LAYER_DOWN = 4'd12,
		ACT_UP_SEND_DONE  = 4'd13,
		ACT_UP_RECEIVE    = 4'd14
	} action_t;

	// open is bit 0, closing is bit 4
	typedef struct packed {
		logic closing;
		logic writing;
		logic reading;
		logic opening;
		logic open;
	} flags_t;

	typedef struct packed {
		logic [STAT_BITS-1:0] open_cnt;
		logic [STAT_BITS-1:0] fail_cnt;
		logic [STAT_BITS-1:0] close_cnt;
		logic [STAT_BITS-1:0] rx_cnt;
		logic [STAT_BITS-1:0] tx_cnt;
	} stats_t;

	typedef struct packed {
		action_t [RUN_MAX-1:0]             act;
		logic [RUN_MAX-1:0][LEN_W-1:0]     bytes;
		logic [RUN_CNT_W-1:0]              count;
	} run_t;

endpackage
`default_nettype wire

// ===== rtl/clc_if.sv =====
`default_nettype none
interface clc_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic        error;
	logic [15:0] length;

	modport source (output valid, output op, output error, output length, input ready);
	modport sink   (input valid, input op, input error, input length, output ready);
endinterface

interface clc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic        last;
	logic [4:0]  status_flags;
	logic [15:0] byte_count;
	logic [31:0] opens_seen;
	logic [31:0] open_fails_seen;
	logic [31:0] closes_seen;
	logic [31:0] rx_bytes;
	logic [31:0] tx_bytes;

	modport source (
		output valid, output action, output last, output status_flags, output byte_count,
		output opens_seen, output open_fails_seen, output closes_seen, output rx_bytes,
		output tx_bytes, input ready
	);
	modport sink (
		input valid, input action, input last, input status_flags, input byte_count,
		input opens_seen, input open_fails_seen, input closes_seen, input rx_bytes,
		input tx_bytes, output ready
	);
endinterface
`default_nettype wire

// ===== rtl/channel_lifecycle_controller.sv =====
`default_nettype none
// channel life-cycle controller: each event item on in_ch (open, close, read, write or
// one of their completions) updates the five channel flags and the wrapping statistics
// counters and yields a run of one to three action items on out_ch, the final one marked
// by last; every item of a run carries the flags and counters as they stand after the
// event. An event waits in the input register until the run buffer can take it, and
// the buffer hands out one action per cycle while out_ch.ready is high; the next event
// is evaluated in the cycle the final action of the previous run is taken, so events
// with a single action flow at one per cycle while out_ch.ready holds. The user is to
// write stats_enable and notify_enable through wr_en/wr_index/wr_data only while the
// block is idle, which the block itself does not enforce; both clear at reset.
`include "channel_lifecycle_controller_assert.svh"
module channel_lifecycle_controller (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire logic wr_index,
	input  wire logic wr_data,
	clc_in_if.sink    in_ch,
	clc_out_if.source out_ch
);
	import clc_pkg::*;

	// configuration
	logic stats_en_q;
	logic notify_en_q;

	// input register stage
	logic             valid_s1;
	op_t              op_s1;
	logic             err_s1;
	logic [LEN_W-1:0] len_s1;

	// channel state
	flags_t flags_q;
	stats_t stats_q;

	// step results
	flags_t flags_n;
	stats_t stats_n;
	run_t   run_n;

	logic run_free;
	logic step_fire;

	// the event in the input register is evaluated once the run buffer can take it
	assign step_fire   = valid_s1 && run_free;
	assign in_ch.ready = !valid_s1 || step_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_en_q  <= 1'b0;
			notify_en_q <= 1'b0;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_STATS_ENABLE:  stats_en_q  <= wr_data;
				CFG_NOTIFY_ENABLE: notify_en_q <= wr_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// payload of the input register, no reset needed
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_s1  <= op_t'(in_ch.op);
			err_s1 <= in_ch.error;
			len_s1 <= in_ch.length[LEN_W-1:0];
		end
	end

	// flags and counters move only when an event is evaluated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			stats_q <= '0;
		end else if (step_fire) begin
			flags_q <= flags_n;
			stats_q <= stats_n;
		end
	end

	clc_step u_step (
		.op        (op_s1),
		.err       (err_s1),
		.len       (len_s1),
		.stats_en  (stats_en_q),
		.notify_en (notify_en_q),
		.flags_i   (flags_q),
		.stats_i   (stats_q),
		.flags_o   (flags_n),
		.stats_o   (stats_n),
		.run_o     (run_n)
	);

	clc_run u_run (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step_fire),
		.run_i   (run_n),
		.flags_i (flags_n),
		.stats_i (stats_n),
		.free    (run_free),
		.out_ch  (out_ch)
	);

	// a none action only ever stands alone
	`CLC_ASSERT_NOW(a_none_alone, clk, arst_n, out_ch.valid && !out_ch.last,
		out_ch.action != ACT_NONE)
	// an evaluated event always presents its run next cycle
	`CLC_ASSERT_NEXT(a_run_loaded, clk, arst_n, step_fire, out_ch.valid)
	// a channel is never open and opening at once
	`CLC_ASSERT_NOW(a_open_excl, clk, arst_n, flags_q.opening, !flags_q.open)
	// no busy transfer flag without an open channel
	`CLC_ASSERT_NOW(a_busy_open, clk, arst_n, flags_q.reading || flags_q.writing,
		flags_q.open)

endmodule
`default_nettype wire

// ===== rtl/clc_step.sv =====
`default_nettype none
module clc_step (
	input  wire clc_pkg::op_t                 op,
	input  wire logic                         err,
	input  wire logic [clc_pkg::LEN_W-1:0]    len,
	input  wire logic                         stats_en,
	input  wire logic                         notify_en,
	input  wire clc_pkg::flags_t              flags_i,
	input  wire clc_pkg::stats_t              stats_i,
	output clc_pkg::flags_t                   flags_o,
	output clc_pkg::stats_t                   stats_o,
	output clc_pkg::run_t                     run_o
);
	import clc_pkg::*;

	// append an action, dropping upward notices when they are masked and any action beyond a full run
	function automatic run_t push_act(input run_t ri, input action_t a,
			input logic [LEN_W-1:0] b, input logic ne);
		run_t ro;
		ro = ri;
		if ((a < ACT_UP_OPEN_FAIL || ne) && ri.count < RUN_CNT_W'(RUN_MAX)) begin
			ro.act[ri.count[RUN_IDX_W-1:0]]   = a;
			ro.bytes[ri.count[RUN_IDX_W-1:0]] = b;
			ro.count = ri.count + RUN_CNT_W'(1);
		end
		return ro;
	endfunction

	function automatic logic will_settle(input flags_t fi);
		return fi.closing && !(fi.opening || fi.reading || fi.writing);
	endfunction

	flags_t f;
	stats_t s;
	run_t   r;
	logic   busy;
	logic   is_read;

	always_comb begin
		f       = flags_i;
		s       = stats_i;
		r       = '0;
		busy    = 1'b0;
		is_read = (op == OP_READ) || (op == OP_READ_DONE);
		unique case (op)
			OP_OPEN: begin
				if (f == '0) begin
					f.opening = 1'b1;
					r = push_act(r, ACT_OPEN, '0, notify_en);
				end else begin
					r = push_act(r, ACT_INVALID, '0, notify_en);
				end
			end
			OP_CLOSE: begin
				if (!f.closing) begin
					if (f.open || f.opening) begin
						if (stats_en) s.close_cnt = s.close_cnt + STAT_BITS'(1);
						f.closing = 1'b1;
						r = push_act(r, f.opening ? ACT_ABORT_OPEN : ACT_CLOSE, '0, notify_en);
					end else begin
						r = push_act(r, ACT_INVALID, '0, notify_en);
					end
				end
				if (will_settle(f)) begin
					f.closing = 1'b0;
					f.open    = 1'b0;
					r = push_act(r, ACT_UP_LAYER_DOWN, '0, notify_en);
				end
			end
			OP_READ, OP_WRITE: begin
				busy = is_read ? f.reading : f.writing;
				if (f.open && !f.closing && !busy) begin
					if (len != '0) begin
						if (is_read) f.reading = 1'b1;
						else f.writing = 1'b1;
						r = push_act(r, is_read ? ACT_READ : ACT_WRITE, len, notify_en);
					end else begin
						r = push_act(r, is_read ? ACT_UP_RECEIVE : ACT_UP_SEND_DONE, '0,
							notify_en);
					end
				end else begin
					r = push_act(r, ACT_INVALID, '0, notify_en);
				end
			end
			OP_READ_DONE, OP_WRITE_DONE: begin
				busy = is_read ? f.reading : f.writing;
				if (!busy) begin
					r = push_act(r, ACT_INVALID, '0, notify_en);
				end else begin
					if (is_read) f.reading = 1'b0;
					else f.writing = 1'b0;
					if (err) begin
						// error tears the channel down if it can still close
						if ((f.open || f.opening) && !f.closing) begin
							if (stats_en) s.close_cnt = s.close_cnt + STAT_BITS'(1);
							f.closing = 1'b1;
							r = push_act(r, f.opening ? ACT_ABORT_OPEN : ACT_CLOSE, '0,
								notify_en);
						end
					end else begin
						if (stats_en) begin
							if (is_read) s.rx_cnt = s.rx_cnt + STAT_BITS'(len);
							else s.tx_cnt = s.tx_cnt + STAT_BITS'(len);
						end
						if (!f.closing) begin
							r = push_act(r, is_read ? ACT_UP_RECEIVE : ACT_UP_SEND_DONE,
								is_read ? len : '0, notify_en);
						end
					end
					if (will_settle(f)) begin
						f.closing = 1'b0;
						f.open    = 1'b0;
						r = push_act(r, ACT_UP_LAYER_DOWN, '0, notify_en);
					end
				end
			end
			OP_OPEN_DONE: begin
				if (!f.opening) begin
					r = push_act(r, ACT_INVALID, '0, notify_en);
				end else begin
					f.opening = 1'b0;
					r = push_act(r, ACT_OPEN_ENDED, '0, notify_en);
					if (err) begin
						if (stats_en) s.fail_cnt = s.fail_cnt + STAT_BITS'(1);
						if (will_settle(f)) begin
							f.closing = 1'b0;
							f.open    = 1'b0;
						end
						r = push_act(r, ACT_OPEN_FAIL_HK, '0, notify_en);
						r = push_act(r, ACT_UP_OPEN_FAIL, '0, notify_en);
					end else if (f.closing) begin
						if (will_settle(f)) begin
							f.closing = 1'b0;
							f.open    = 1'b0;
						end
						r = push_act(r, ACT_CLOSE, '0, notify_en);
						r = push_act(r, ACT_UP_OPEN_FAIL, '0, notify_en);
					end else begin
						if (stats_en) s.open_cnt = s.open_cnt + STAT_BITS'(1);
						f.open = 1'b1;
						r = push_act(r, ACT_OPEN_OK_HK, '0, notify_en);
						r = push_act(r, ACT_UP_LAYER_UP, '0, notify_en);
					end
				end
			end
			default: begin
				r = push_act(r, ACT_INVALID, '0, notify_en);
			end
		endcase
		// an empty run still yields one item
		if (r.count == '0) begin
			r.act[0]   = ACT_NONE;
			r.bytes[0] = '0;
			r.count    = RUN_CNT_W'(1);
		end
		flags_o = f;
		stats_o = s;
		run_o   = r;
	end

endmodule
`default_nettype wire

// ===== rtl/clc_run.sv =====
`default_nettype none
module clc_run (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire clc_pkg::run_t   run_i,
	input  wire clc_pkg::flags_t flags_i,
	input  wire clc_pkg::stats_t stats_i,
	output logic                 free,
	clc_out_if.source            out_ch
);
	import clc_pkg::*;

	logic                 valid_q;
	logic [RUN_IDX_W-1:0] idx_q;
	run_t                 run_q;
	flags_t               flags_q;
	stats_t               stats_q;
	logic                 last;
	logic                 take;

	assign last = (RUN_CNT_W'(idx_q) + RUN_CNT_W'(1)) == run_q.count;
	assign take = valid_q && out_ch.ready;
	// buffer can refill when empty or when its final item leaves now
	assign free = !valid_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (last) valid_q <= 1'b0;
			else idx_q <= idx_q + RUN_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q   <= run_i;
			flags_q <= flags_i;
			stats_q <= stats_i;
		end
	end

	assign out_ch.valid           = valid_q;
	assign out_ch.action          = run_q.act[idx_q];
	assign out_ch.last            = last;
	assign out_ch.status_flags    = flags_q;
	assign out_ch.byte_count      = 16'(run_q.bytes[idx_q]);
	assign out_ch.opens_seen      = 32'(stats_q.open_cnt);
	assign out_ch.open_fails_seen = 32'(stats_q.fail_cnt);
	assign out_ch.closes_seen     = 32'(stats_q.close_cnt);
	assign out_ch.rx_bytes        = 32'(stats_q.rx_cnt);
	assign out_ch.tx_bytes        = 32'(stats_q.tx_cnt);

endmodule
`default_nettype wire

// ===== test/tb_channel_lifecycle_controller.sv =====
`default_nettype none
module tb_channel_lifecycle_controller;
	import clc_pkg::*;

	// op code 7 has no meaning and must be refused
	localparam logic [2:0] OP_RESERVED = 3'd7;
	localparam int CYCLE_LIMIT = 500000;

	// one event item waiting to be sent, with an optional hold until the block drains
	typedef struct {
		logic [2:0]  op;
		logic        err;
		logic [15:0] len;
		bit          drain;
	} request_t;

	// one action item as the block should present it
	typedef struct packed {
		logic [3:0]  action;
		logic        last;
		logic [4:0]  flags;
		logic [15:0] bytes;
		logic [31:0] opens;
		logic [31:0] fails;
		logic [31:0] closes;
		logic [31:0] rx;
		logic [31:0] tx;
	} action_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic wr_index;
	logic wr_data;

	clc_in_if  in_ch ();
	clc_out_if out_ch ();

	channel_lifecycle_controller i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_index (wr_index),
		.wr_data (wr_data),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus waiting for the driver, and actions waiting for the monitor
	request_t     queued_requests[$];
	action_item_t due_actions[$];

	// mirror of the channel: flags, counters and the two register bits
	flags_t      chan = '0;
	logic [31:0] n_opens = '0;
	logic [31:0] n_fails = '0;
	logic [31:0] n_closes = '0;
	logic [31:0] n_rx = '0;
	logic [31:0] n_tx = '0;
	bit          stats_on = 1'b0;
	bit          notify_on = 1'b0;

	// run of actions for the event being worked out
	action_t     run_act[$];
	logic [15:0] run_bytes[$];

	int           items_planned = 0;
	int           items_sent = 0;
	int           results_seen = 0;
	int           mismatches = 0;
	int           cycles = 0;
	int           send_gap = 0;
	int           stall_left = 0;
	bit           quiet = 1'b0;
	request_t     next_req;
	action_item_t head_item;

	// --------------------------------------------------------------------
	// channel mirror
	// --------------------------------------------------------------------

	// upward notices vanish when notify is off; a run never exceeds three
	function automatic void emit(action_t act, logic [15:0] bytes);
		if (act >= ACT_UP_OPEN_FAIL && !notify_on)
			return;
		if (run_act.size() < RUN_MAX) begin
			run_act.push_back(act);
			run_bytes.push_back(bytes);
		end
	endfunction

	function automatic bit busy_any();
		return chan.opening | chan.reading | chan.writing;
	endfunction

	function automatic bit closable();
		return (chan.open | chan.opening) & ~chan.closing;
	endfunction

	// a pending close completes once nothing is outstanding
	function automatic bit finish_close();
		if (chan.closing && !busy_any()) begin
			chan.closing = 1'b0;
			chan.open    = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// a close while already closing is silently swallowed
	function automatic void begin_close();
		if (chan.closing)
			return;
		if (closable()) begin
			if (stats_on)
				n_closes++;
			chan.closing = 1'b1;
			if (chan.opening)
				emit(ACT_ABORT_OPEN, '0);
			else
				emit(ACT_CLOSE, '0);
		end else begin
			emit(ACT_INVALID, '0);
		end
	endfunction

	// read or write request; zero length completes straight away
	function automatic void start_transfer(bit is_read, logic [15:0] len);
		bit busy;
		busy = is_read ? chan.reading : chan.writing;
		if (chan.open && !chan.closing && !busy) begin
			if (len != '0) begin
				if (is_read) begin
					chan.reading = 1'b1;
					emit(ACT_READ, len);
				end else begin
					chan.writing = 1'b1;
					emit(ACT_WRITE, len);
				end
			end else if (is_read) begin
				emit(ACT_UP_RECEIVE, '0);
			end else begin
				emit(ACT_UP_SEND_DONE, '0);
			end
		end else begin
			emit(ACT_INVALID, '0);
		end
	endfunction

	// read or write completion; an error tears the channel down
	function automatic void complete_transfer(bit is_read, bit err, logic [15:0] len);
		bit busy;
		busy = is_read ? chan.reading : chan.writing;
		if (!busy) begin
			emit(ACT_INVALID, '0);
			return;
		end
		if (is_read)
			chan.reading = 1'b0;
		else
			chan.writing = 1'b0;
		if (err) begin
			if (closable())
				begin_close();
		end else begin
			if (stats_on) begin
				if (is_read)
					n_rx += len;
				else
					n_tx += len;
			end
			if (!chan.closing) begin
				if (is_read)
					emit(ACT_UP_RECEIVE, len);
				else
					emit(ACT_UP_SEND_DONE, '0);
			end
		end
		if (finish_close())
			emit(ACT_UP_LAYER_DOWN, '0);
	endfunction

	function automatic void complete_open(bit err);
		if (!chan.opening) begin
			emit(ACT_INVALID, '0);
			return;
		end
		chan.opening = 1'b0;
		emit(ACT_OPEN_ENDED, '0);
		if (err) begin
			if (stats_on)
				n_fails++;
			void'(finish_close());
			emit(ACT_OPEN_FAIL_HK, '0);
			emit(ACT_UP_OPEN_FAIL, '0);
		end else if (chan.closing) begin
			// close arrived while opening: the open ends as a close
			void'(finish_close());
			emit(ACT_CLOSE, '0);
			emit(ACT_UP_OPEN_FAIL, '0);
		end else begin
			if (stats_on)
				n_opens++;
			chan.open = 1'b1;
			emit(ACT_OPEN_OK_HK, '0);
			emit(ACT_UP_LAYER_UP, '0);
		end
	endfunction

	// works out the action run of one accepted event and queues it
	function automatic void apply_event(logic [2:0] op, logic err, logic [15:0] len);
		action_item_t item;
		run_act.delete();
		run_bytes.delete();
		case (op)
			OP_OPEN: begin
				if (chan == '0) begin
					chan.opening = 1'b1;
					emit(ACT_OPEN, '0);
				end else begin
					emit(ACT_INVALID, '0);
				end
			end
			OP_CLOSE: begin
				begin_close();
				if (finish_close())
					emit(ACT_UP_LAYER_DOWN, '0);
			end
			OP_READ:       start_transfer(1'b1, len);
			OP_WRITE:      start_transfer(1'b0, len);
			OP_OPEN_DONE:  complete_open(err);
			OP_READ_DONE:  complete_transfer(1'b1, err, len);
			OP_WRITE_DONE: complete_transfer(1'b0, err, len);
			default:       emit(ACT_INVALID, '0);
		endcase
		// an event with nothing to say still yields one empty action
		if (run_act.size() == 0) begin
			run_act.push_back(ACT_NONE);
			run_bytes.push_back('0);
		end
		for (int k = 0; k < run_act.size(); k++) begin
			item.action = run_act[k];
			item.last   = (k == run_act.size() - 1);
			item.flags  = chan;
			item.bytes  = run_bytes[k];
			item.opens  = n_opens;
			item.fails  = n_fails;
			item.closes = n_closes;
			item.rx     = n_rx;
			item.tx     = n_tx;
			due_actions.push_back(item);
		end
	endfunction

	// --------------------------------------------------------------------
	// stimulus helpers
	// --------------------------------------------------------------------

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// lengths lean on the edges: zero, one and all ones
	function automatic logic [15:0] rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return 16'hffff;
		if (r < 28)
			return 16'd1;
		return 16'($urandom_range(1, 65535));
	endfunction

	function automatic bit rand_err(int pct);
		return ($urandom_range(0, 99) < pct);
	endfunction

	task automatic add_item(logic [2:0] op, logic err, logic [15:0] len, bit drain = 1'b0);
		request_t req;
		req.op    = op;
		req.err   = err;
		req.len   = len;
		req.drain = drain;
		queued_requests.push_back(req);
		items_planned++;
	endtask

	// a completion with its error chance
	task automatic add_done(logic [2:0] op);
		add_item(op, rand_err(8), rand_len());
	endtask

	// a well-formed channel session with random content; errors and early
	// closes take it off the happy path now and then
	task automatic add_session();
		int r;
		int n;
		add_item(OP_OPEN, rand_err(50), 16'($urandom), rand_err(3));
		r = $urandom_range(0, 99);
		if (r < 12) begin
			add_item(OP_OPEN_DONE, 1'b1, 16'($urandom));
			return;
		end
		if (r < 22) begin
			// close while the open is still in flight
			add_item(OP_CLOSE, rand_err(50), 16'($urandom));
			add_item(OP_OPEN_DONE, rand_err(50), 16'($urandom));
			return;
		end
		add_item(OP_OPEN_DONE, 1'b0, 16'($urandom));
		n = $urandom_range(0, 4);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: begin
					add_item(OP_READ, rand_err(50), rand_len());
					add_done(OP_READ_DONE);
				end
				1: begin
					add_item(OP_WRITE, rand_err(50), rand_len());
					add_done(OP_WRITE_DONE);
				end
				2: begin
					// read and write overlapping
					add_item(OP_READ, rand_err(50), rand_len());
					add_item(OP_WRITE, rand_err(50), rand_len());
					add_done(OP_WRITE_DONE);
					add_done(OP_READ_DONE);
				end
				default: begin
					// close with a read outstanding, the read finishes it
					add_item(OP_READ, rand_err(50), rand_len());
					add_item(OP_CLOSE, rand_err(50), 16'($urandom));
					add_done(OP_READ_DONE);
					return;
				end
			endcase
		end
		add_item(OP_CLOSE, rand_err(50), 16'($urandom));
	endtask

	// sessions with some noise mixed in, until the item count reaches the mark
	task automatic fill_random(int upto);
		while (items_planned < upto) begin
			if ($urandom_range(0, 99) < 15)
				add_item(3'($urandom_range(0, 7)), 1'($urandom), 16'($urandom));
			else
				add_session();
		end
	endtask

	// returns once the sender is empty and every action has come back
	task automatic wait_idle();
		do
			@(posedge clk);
		while (queued_requests.size() != 0 || in_ch.valid || due_actions.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_registers(bit stats_val, bit notify_val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= CFG_STATS_ENABLE;
		wr_data  <= stats_val;
		stats_on = stats_val;
		@(posedge clk);
		wr_index <= CFG_NOTIFY_ENABLE;
		wr_data  <= notify_val;
		notify_on = notify_val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// --------------------------------------------------------------------
	// driver: sends queued event items, works out the run on acceptance
	// --------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid  <= 1'b0;
			in_ch.op     <= OP_OPEN;
			in_ch.error  <= 1'b0;
			in_ch.length <= '0;
			send_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				apply_event(in_ch.op, in_ch.error, in_ch.length);
				items_sent++;
			end
			// slot is free: either nothing was offered or it was just taken
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (queued_requests.size() != 0 &&
						!(queued_requests[0].drain && due_actions.size() != 0)) begin
					next_req = queued_requests.pop_front();
					in_ch.valid  <= 1'b1;
					in_ch.op     <= next_req.op;
					in_ch.error  <= next_req.err;
					in_ch.length <= next_req.len;
					send_gap = pick_gap();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// --------------------------------------------------------------------
	// monitor: random back-pressure, each action checked against the oldest due
	// --------------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (due_actions.size() == 0) begin
					$error("action item %0d arrived with none outstanding", out_ch.action);
					mismatches++;
				end else begin
					head_item = due_actions.pop_front();
					check_field("action", head_item.action, out_ch.action);
					check_field("last", head_item.last, out_ch.last);
					check_field("status_flags", head_item.flags, out_ch.status_flags);
					check_field("byte_count", head_item.bytes, out_ch.byte_count);
					check_field("opens_seen", head_item.opens, out_ch.opens_seen);
					check_field("open_fails_seen", head_item.fails, out_ch.open_fails_seen);
					check_field("closes_seen", head_item.closes, out_ch.closes_seen);
					check_field("rx_bytes", head_item.rx, out_ch.rx_bytes);
					check_field("tx_bytes", head_item.tx, out_ch.tx_bytes);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// sequence of the run
	// --------------------------------------------------------------------
	initial begin
		// every input known before the first edge
		arst_n       = 1'b0;
		wr_en        = 1'b0;
		wr_index     = 1'b0;
		wr_data      = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.op     = OP_OPEN;
		in_ch.error  = 1'b0;
		in_ch.length = '0;
		out_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: statistics and notices both on
		set_registers(1'b1, 1'b1);
		// refusals from the closed state, including the reserved op
		add_item(OP_READ, 1'b0, 16'd4);
		add_item(OP_WRITE_DONE, 1'b0, 16'd4);
		add_item(OP_OPEN_DONE, 1'b0, '0);
		add_item(OP_CLOSE, 1'b0, '0);
		add_item(OP_RESERVED, 1'b1, 16'hffff);
		// failed open, then a second open refused while opening
		add_item(OP_OPEN, 1'b0, '0);
		add_item(OP_OPEN, 1'b0, '0);
		add_item(OP_OPEN_DONE, 1'b1, 16'h1234);
		// close during opening, a repeated close gives the empty run
		add_item(OP_OPEN, 1'b0, '0, 1'b1);
		add_item(OP_CLOSE, 1'b0, '0);
		add_item(OP_CLOSE, 1'b0, '0);
		add_item(OP_OPEN_DONE, 1'b0, '0);
		// good open, zero-length and full-length transfers
		add_item(OP_OPEN, 1'b1, 16'hffff);
		add_item(OP_OPEN_DONE, 1'b0, 16'hffff);
		add_item(OP_READ, 1'b0, '0);
		add_item(OP_WRITE, 1'b1, '0);
		add_item(OP_READ, 1'b0, 16'hffff);
		add_item(OP_READ, 1'b0, 16'd3);
		add_item(OP_WRITE, 1'b0, 16'hffff);
		add_item(OP_READ_DONE, 1'b0, 16'hffff);
		add_item(OP_WRITE_DONE, 1'b0, 16'hffff);
		// close with a write in flight; a failed write then lets it finish
		add_item(OP_WRITE, 1'b0, 16'd7);
		add_item(OP_CLOSE, 1'b0, '0);
		add_item(OP_WRITE, 1'b0, 16'd1);
		add_item(OP_WRITE_DONE, 1'b1, 16'd7);
		// a failed read closes an open channel by itself
		add_item(OP_OPEN, 1'b0, '0);
		add_item(OP_OPEN_DONE, 1'b0, '0);
		add_item(OP_READ, 1'b0, 16'd9);
		add_item(OP_READ_DONE, 1'b1, 16'd9);
		wait_idle();

		// random phases across the register settings; the last has no idling
		fill_random(90);
		wait_idle();
		set_registers(1'b0, 1'b1);
		fill_random(150);
		wait_idle();
		set_registers(1'b1, 1'b0);
		fill_random(210);
		wait_idle();
		set_registers(1'b0, 1'b0);
		quiet = 1'b1;
		fill_random(270);
		wait_idle();
		repeat (8) @(posedge clk);

		$display("tb: %0d event items sent, %0d action items checked", items_sent, results_seen);
		$display("tb: all four statistics/notice settings, with and without idling");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
